// ===== rtl/length_prefixed_word_packer_defines.svh =====
// Assertion macros shared by the length-prefixed word packer RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef LENGTH_PREFIXED_WORD_PACKER_DEFINES_SVH
`define LENGTH_PREFIXED_WORD_PACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define LPWP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lpwp assertion failed");
// Condition must never be true at a rising edge outside reset.
`define LPWP_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lpwp forbidden condition seen");
`else
`define LPWP_ASSERT(lbl, clk, rst, prop)
`define LPWP_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== rtl/lpwp_pkg.sv =====
// Shared types and constants of the length-prefixed word packer.
// Used by the front, back and top-level modules; no dependencies.
package lpwp_pkg;

  localparam int KEY_BITS_DEFAULT  = 64;
  localparam int CMD_DEPTH_DEFAULT = 4;
  localparam int RES_DEPTH_DEFAULT = 2;

  localparam int WORD_BYTES   = 32;
  localparam int WORD_BITS    = 256;
  localparam int LEN_BITS     = 13;
  localparam int SLOT_BITS    = 5;

  localparam logic [LEN_BITS-1:0]  LEN_LIMIT_RESET = 13'd8190;
  localparam logic [SLOT_BITS-1:0] HEADER_BYTES    = 5'd2;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT       = 5'd31;

  localparam logic [1:0] STATUS_WORD     = 2'd0;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
  localparam logic [1:0] STATUS_STRAY    = 2'd2;

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_OVERSIZE,
    KIND_DATA
  } kind_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    kind_t               kind;
    logic [LEN_BITS-1:0] len;
    logic [7:0]          data;
  } cmd_t;

  // Result without its key; the key width follows the KEY_BITS parameter.
  typedef struct packed {
    logic [1:0]           status;
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } res_t;

endpackage

// ===== rtl/lpwp_queue.sv =====
// Small register-based FIFO used between the packer stages and at the output.
// Standalone; no package dependency.
`include "length_prefixed_word_packer_defines.svh"

module lpwp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `LPWP_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `LPWP_ASSERT(a_push_grows, clk, rst, (do_push && !do_pop) |=> count == $past(count) + 1'b1)
  `LPWP_ASSERT(a_pop_shrinks, clk, rst, (do_pop && !do_push) |=> count == $past(count) - 1'b1)

endmodule

// ===== rtl/lpwp_front.sv =====
// Front stage: holds the length limit register and classifies input items.
// Depends on lpwp_pkg.
module lpwp_front #(
  parameter int KEY_BITS = lpwp_pkg::KEY_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [12:0]          cfg_data,
  input  logic                 opcode,
  input  logic [63:0]          start_key,
  input  logic [15:0]          record_length,
  input  logic [7:0]           data_byte,
  output lpwp_pkg::cmd_t       cmd,
  output logic [KEY_BITS-1:0]  cmd_key
);

  logic [lpwp_pkg::LEN_BITS-1:0] max_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lpwp_pkg::LEN_LIMIT_RESET;
    end else if (cfg_write) begin
      max_len <= cfg_data;
    end
  end

  // A begin whose length is over the limit is marked here so the back
  // stage needs no compare of its own.
  always_comb begin
    if (opcode) begin
      cmd.kind = lpwp_pkg::KIND_DATA;
    end else if (record_length > {3'b000, max_len}) begin
      cmd.kind = lpwp_pkg::KIND_OVERSIZE;
    end else begin
      cmd.kind = lpwp_pkg::KIND_BEGIN;
    end
    cmd.len  = record_length[lpwp_pkg::LEN_BITS-1:0];
    cmd.data = data_byte;
  end

  assign cmd_key = start_key[KEY_BITS-1:0];

endmodule

// ===== rtl/lpwp_back.sv =====
// Back stage: packs record bytes into 256-bit words and forms the results.
// Depends on lpwp_pkg and the assertion macro header.
`include "length_prefixed_word_packer_defines.svh"

module lpwp_back #(
  parameter int KEY_BITS = lpwp_pkg::KEY_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  lpwp_pkg::cmd_t      cmd,
  input  logic [KEY_BITS-1:0] cmd_key,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output lpwp_pkg::res_t      res,
  output logic [KEY_BITS-1:0] res_key
);

  logic [lpwp_pkg::WORD_BITS-1:0] word_buffer;
  logic [lpwp_pkg::SLOT_BITS-1:0] byte_slot;
  logic [lpwp_pkg::LEN_BITS-1:0]  bytes_left;
  logic [KEY_BITS-1:0]            current_key;
  logic                           record_open;
  logic [lpwp_pkg::WORD_BITS-1:0] word_ins;
  logic [lpwp_pkg::WORD_BITS-1:0] word_head;

  assign cmd_pop   = cmd_valid && !res_full;
  assign word_head = {3'b000, cmd.len, 240'd0};

  // Byte lane 0 is the most significant byte of the word.
  always_comb begin
    word_ins = word_buffer;
    for (int i = 0; i < lpwp_pkg::WORD_BYTES; i++) begin
      if (byte_slot == lpwp_pkg::SLOT_BITS'(i)) begin
        word_ins[255 - 8 * i -: 8] = word_buffer[255 - 8 * i -: 8] | cmd.data;
      end
    end
  end

  always_comb begin
    res_push   = 1'b0;
    res.status = lpwp_pkg::STATUS_WORD;
    res.word   = '0;
    res.last   = 1'b0;
    res_key    = '0;
    case (cmd.kind)
      lpwp_pkg::KIND_OVERSIZE: begin
        res_push   = cmd_pop;
        res.status = lpwp_pkg::STATUS_OVERSIZE;
      end
      lpwp_pkg::KIND_BEGIN: begin
        if (cmd.len == '0) begin
          res_push = cmd_pop;
          res.word = word_head;
          res.last = 1'b1;
          res_key  = cmd_key;
        end
      end
      lpwp_pkg::KIND_DATA: begin
        if (!record_open) begin
          res_push   = cmd_pop;
          res.status = lpwp_pkg::STATUS_STRAY;
        end else if (bytes_left == 13'd1) begin
          res_push = cmd_pop;
          res.word = word_ins;
          res.last = 1'b1;
          res_key  = current_key;
        end else if (byte_slot == lpwp_pkg::LAST_SLOT) begin
          res_push = cmd_pop;
          res.word = word_ins;
          res_key  = current_key;
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_open <= 1'b0;
      byte_slot   <= '0;
      bytes_left  <= '0;
    end else if (cmd_pop) begin
      case (cmd.kind)
        lpwp_pkg::KIND_OVERSIZE: begin
          record_open <= 1'b0;
          byte_slot   <= '0;
          bytes_left  <= '0;
        end
        lpwp_pkg::KIND_BEGIN: begin
          word_buffer <= word_head;
          byte_slot   <= lpwp_pkg::HEADER_BYTES;
          bytes_left  <= cmd.len;
          current_key <= cmd_key;
          record_open <= (cmd.len != '0);
        end
        lpwp_pkg::KIND_DATA: begin
          if (record_open) begin
            bytes_left <= bytes_left - 1'b1;
            if (bytes_left == 13'd1) begin
              word_buffer <= word_ins;
              byte_slot   <= byte_slot + 1'b1;
              record_open <= 1'b0;
            end else if (byte_slot == lpwp_pkg::LAST_SLOT) begin
              word_buffer <= '0;
              byte_slot   <= '0;
              current_key <= current_key + KEY_BITS'(1);
            end else begin
              word_buffer <= word_ins;
              byte_slot   <= byte_slot + 1'b1;
            end
          end
        end
        default: begin
          record_open <= record_open;
        end
      endcase
    end
  end

  `LPWP_ASSERT(a_push_needs_pop, clk, rst, res_push |-> cmd_pop)
  `LPWP_ASSERT(a_open_has_bytes, clk, rst, record_open |-> bytes_left != '0)
  `LPWP_ASSERT(a_last_byte_closes, clk, rst, (cmd_pop && cmd.kind == lpwp_pkg::KIND_DATA && record_open && bytes_left == 13'd1) |=> !record_open)

endmodule

// ===== rtl/length_prefixed_word_packer.sv =====
// Top level of the length-prefixed word packer.
// Depends on lpwp_pkg, lpwp_front, lpwp_queue and lpwp_back.
//
// Usage: items enter through a queue-like port. An item transfers at a rising
// edge where push is high and full is low. Opcode 0 begins a record with
// start_key and record_length; opcode 1 carries one data_byte of the record.
// Results leave through a second queue-like port: while empty is low the
// oldest result is on status, word_key, the four word_bits ports and
// last_word, and it transfers at an edge where pop is high.
// Each packed word goes out with its key once it is full or once the last
// byte of the record arrives. Oversize begins and bytes outside a record
// give a status-only result with zero key and data.
// A result reaches the output ports through the command and result queues.
// Throughput: one item per cycle, set by the back stage, which retires one
// queued command per cycle while the result queue is not full.
// The length limit is written through cfg_write and cfg_data; the user must
// write it only while idle, and the block itself does not enforce this.
// Reset clears both queues, closes any open record and restores the limit
// to 8190 bytes. When the receiver stalls, the output queue fills, the back
// stage stops retiring commands, and the command queue raises full.
module length_prefixed_word_packer #(
  parameter int KEY_BITS  = lpwp_pkg::KEY_BITS_DEFAULT,
  parameter int CMD_DEPTH = lpwp_pkg::CMD_DEPTH_DEFAULT,
  parameter int RES_DEPTH = lpwp_pkg::RES_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [12:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [63:0] start_key,
  input  logic [15:0] record_length,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [63:0] word_key,
  output logic [63:0] word_bits_255_192,
  output logic [63:0] word_bits_191_128,
  output logic [63:0] word_bits_127_64,
  output logic [63:0] word_bits_63_0,
  output logic        last_word
);

  localparam int CMD_W = KEY_BITS + $bits(lpwp_pkg::cmd_t);
  localparam int RES_W = KEY_BITS + $bits(lpwp_pkg::res_t);

  lpwp_pkg::cmd_t      front_cmd;
  logic [KEY_BITS-1:0] front_key;
  logic [CMD_W-1:0]    cmdq_rdata;
  logic                cmdq_empty;
  lpwp_pkg::cmd_t      back_cmd;
  logic [KEY_BITS-1:0] back_key;
  logic                cmd_pop;
  logic                res_full;
  logic                res_push;
  lpwp_pkg::res_t      back_res;
  logic [KEY_BITS-1:0] back_res_key;
  logic [RES_W-1:0]    resq_rdata;
  lpwp_pkg::res_t      out_res;
  logic [KEY_BITS-1:0] out_key;

  // The front stage classifies each item as it is pushed.
  lpwp_front #(
    .KEY_BITS(KEY_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .start_key    (start_key),
    .record_length(record_length),
    .data_byte    (data_byte),
    .cmd          (front_cmd),
    .cmd_key      (front_key)
  );

  // The command queue decouples the input side from the packer.
  lpwp_queue #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({front_key, front_cmd}),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cmdq_rdata),
    .empty(cmdq_empty)
  );

  assign {back_key, back_cmd} = cmdq_rdata;

  lpwp_back #(
    .KEY_BITS(KEY_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cmdq_empty),
    .cmd      (back_cmd),
    .cmd_key  (back_key),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res),
    .res_key  (back_res_key)
  );

  // The result queue holds finished words while the receiver stalls.
  lpwp_queue #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata({back_res_key, back_res}),
    .full (res_full),
    .pop  (pop),
    .rdata(resq_rdata),
    .empty(empty)
  );

  assign {out_key, out_res} = resq_rdata;

  assign status            = out_res.status;
  assign word_key          = 64'(out_key);
  assign word_bits_255_192 = out_res.word[255:192];
  assign word_bits_191_128 = out_res.word[191:128];
  assign word_bits_127_64  = out_res.word[127:64];
  assign word_bits_63_0    = out_res.word[63:0];
  assign last_word         = out_res.last;

endmodule
